[sv/gpfk_pkg.sv]
// Shared types, constants and saturation helpers for the Gaussian force kernel.
package gpfk_pkg;

  typedef enum logic [2:0] {
    REG_CENTER   = 3'd0,
    REG_DIAG     = 3'd1,
    REG_OFFDIAG  = 3'd2,
    REG_CHARGE   = 3'd3,
    REG_JSCALE   = 3'd4
  } reg_index_t;

  localparam int CFG_DATA_W = 48;
  localparam int OUT_W      = 32;
  localparam int PROD_W     = 62;
  localparam int WIDE_W     = 128;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam prod_t PROD_MAX = prod_t'(64'sd1 <<< 60);
  localparam prod_t PROD_MIN = -PROD_MAX;

  // Clamp a full product to +-2^60.
  function automatic prod_t sat60(input wide_t p);
    prod_t r;
    if (p > wide_t'(PROD_MAX)) begin
      r = PROD_MAX;
    end else if (p < wide_t'(PROD_MIN)) begin
      r = PROD_MIN;
    end else begin
      r = p[PROD_W-1:0];
    end
    return r;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/gpfk_front.sv]
// Front stages: offset, matrix product, quadratic form, outer-product terms and table index.
module gpfk_front #(
  parameter int COORD_WIDTH     = 16,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [COORD_WIDTH-1:0]         pos [3],
  input  logic signed [15:0]                    center [3],
  input  logic signed [15:0]                    smat [6],
  output logic                                  out_valid,
  output logic signed [gpfk_pkg::PROD_W-1:0]    y_out [3],
  output logic signed [63:0]                    m_out [6],
  output logic [$clog2(EXP_TABLE_DEPTH)-1:0]    idx_out,
  output logic                                  in_range
);
  import gpfk_pkg::*;

  localparam int DW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
  localparam int YW = DW + 18;
  localparam int IW = $clog2(EXP_TABLE_DEPTH);

  // smat order: xx, xy, xz, yy, yz, zz
  localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

  function automatic int sidx(input int a, input int b);
    int r;
    r = 0;
    for (int k = 0; k < 6; k++) begin
      if ((PA[k] == a && PB[k] == b) || (PA[k] == b && PB[k] == a)) r = k;
    end
    return r;
  endfunction

  logic               v1, v2, v3;
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [YW-1:0] y2 [3];
  prod_t              dy3 [3];
  prod_t              yy3 [6];
  prod_t              y3 [3];

  logic signed [YW-1:0] y_next [3];
  logic signed [63:0]   q_sum;
  logic signed [63:0]   m_next [6];
  logic [63:0]          idx_prod;
  logic [63:0]          idx_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y_next[i] = '0;
      for (int j = 0; j < 3; j++) begin
        y_next[i] = y_next[i] + YW'(smat[sidx(i, j)]) * YW'(d1[j]);
      end
    end
  end

  always_comb begin
    q_sum = 64'(dy3[0]) + 64'(dy3[1]) + 64'(dy3[2]);
    if (q_sum < 0) q_sum = '0;
    idx_prod = {35'd0, q_sum[28:0]} * 64'(EXP_TABLE_DEPTH);
    idx_full = idx_prod >> 29;
    if (idx_full > 64'(EXP_TABLE_DEPTH - 1)) idx_full = 64'(EXP_TABLE_DEPTH - 1);
    for (int k = 0; k < 6; k++) begin
      m_next[k] = (64'(smat[k]) <<< 24) - 64'(yy3[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= DW'(pos[i]) - DW'(center[i]);
        d2[i] <= d1[i];
        y2[i] <= y_next[i];
        dy3[i] <= sat60(wide_t'(d2[i]) * wide_t'(y2[i]));
        y3[i] <= prod_t'(y2[i]);
        y_out[i] <= y3[i];
      end
      for (int k = 0; k < 6; k++) begin
        yy3[k] <= sat60(wide_t'(y2[PA[k]]) * wide_t'(y2[PB[k]]));
        m_out[k] <= m_next[k];
      end
      in_range <= (q_sum < 64'sd536870912);
      idx_out <= idx_full[IW-1:0];
    end
  end

endmodule

[sv/gpfk_exp.sv]
// Exponential table lookup and energy scaling by charge.
module gpfk_exp #(
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [$clog2(EXP_TABLE_DEPTH)-1:0]  idx,
  input  logic                                in_range,
  input  logic signed [gpfk_pkg::PROD_W-1:0]  y_in [3],
  input  logic signed [63:0]                  m_in [6],
  input  logic signed [15:0]                  charge,
  output logic                                out_valid,
  output logic signed [31:0]                  energy,
  output logic signed [gpfk_pkg::PROD_W-1:0]  y_out [3],
  output logic signed [63:0]                  m_out [6]
);
  import gpfk_pkg::*;

  typedef logic [30:0] tab_t [EXP_TABLE_DEPTH];

  // Floor quotient of two nonnegative values by shift and subtract.
  function automatic longint udiv(input longint n, input longint d);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((n >>> b) & 64'sd1);
      if (rem >= d) begin
        rem = rem - d;
        q   = q | (64'sd1 <<< b);
      end
    end
    return q;
  endfunction

  // Entry k = exp(-16k/depth) in unsigned Q1.30: Taylor series at x/32, squared five times.
  function automatic tab_t build_tab();
    tab_t   r;
    longint t;
    longint term;
    longint sum;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      t    = udiv(longint'(k) <<< 29, longint'(EXP_TABLE_DEPTH));
      term = longint'(1) <<< 30;
      sum  = term;
      for (int i = 1; i <= 12; i++) begin
        term = udiv((term * t) >>> 30, longint'(i));
        sum  = ((i & 1) == 1) ? sum - term : sum + term;
      end
      for (int n = 0; n < 5; n++) begin
        sum = (sum * sum + (longint'(1) <<< 29)) >>> 30;
      end
      r[k] = sum[30:0];
    end
    return r;
  endfunction

  localparam tab_t EXP_TAB = build_tab();

  logic               v1;
  logic [30:0]        tval;
  logic               rng1;
  prod_t              y1 [3];
  logic signed [63:0] m1 [6];
  logic signed [47:0] ce;

  assign ce = 48'(charge) * $signed({17'd0, tval});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    if (en) begin
      tval <= EXP_TAB[idx];
      rng1 <= in_range;
      y1 <= y_in;
      m1 <= m_in;
      energy <= rng1 ? 32'(ce >>> 22) : '0;
      y_out <= y1;
      m_out <= m1;
    end
  end

endmodule

[sv/gpfk_back.sv]
// Back stages: force and Jacobian products with output saturation.
module gpfk_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [31:0]                  energy,
  input  logic signed [gpfk_pkg::PROD_W-1:0]  y_in [3],
  input  logic signed [63:0]                  m_in [6],
  input  logic signed [15:0]                  jscale,
  output logic                                out_valid,
  output logic [319:0]                        result
);
  import gpfk_pkg::*;

  logic               v1;
  prod_t              fy1 [3];
  prod_t              tm1 [6];
  logic signed [31:0] e1;
  prod_t              js [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      js[k] = sat60(wide_t'(tm1[k] >>> 16) * wide_t'(jscale));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    if (en) begin
      e1 <= energy;
      for (int i = 0; i < 3; i++) begin
        fy1[i] <= sat60(wide_t'(y_in[i]) * wide_t'(energy));
        result[32*i +: 32] <= sat32(64'(fy1[i] >>> 16));
      end
      for (int k = 0; k < 6; k++) begin
        tm1[k] <= sat60(wide_t'(m_in[k] >>> 16) * wide_t'(energy));
        result[128 + 32*k +: 32] <= sat32(64'(js[k] >>> 8));
      end
      result[96 +: 32] <= e1;
    end
  end

endmodule

[sv/gaussian_potential_force_kernel_core.sv]
// Top level of the Gaussian potential force and Jacobian kernel.
//
// Channel   Direction  Transfer when            Payload
// s_axis    in         s_axis_tvalid & tready  pos_x, pos_y, pos_z
// m_axis    out        m_axis_tvalid & tready  force xyz, energy, six Jacobian entries
// cfg       in         cfg_valid & cfg_ready   register index, 48-bit data
//
// One vertex enters per cycle while the pipeline is not held.
// The latency is set by the chain of wide multiplies and the registered table read.
// The whole pipeline holds while the output register is full and not taken, so
// s_axis_tready drops only during such a hold; bubbles travel as cleared valid bits.
// Reset clears all valid bits and loads the register reset values; the
// exponential table is a constant ROM and needs no fill.
module gaussian_potential_force_kernel_core #(
  parameter int EXP_TABLE_DEPTH = 1024,
  parameter int COORD_WIDTH     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pos_x, pos_y, pos_z from bit 0 up, zero-filled to whole bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // force_x, force_y, force_z, vertex_energy, jac_xx, jac_xy, jac_xz,
  // jac_yy, jac_yz, jac_zz from bit 0 up, 32 bits each
  output logic [319:0]                         m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [gpfk_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gpfk_pkg::*;

  localparam int IW = $clog2(EXP_TABLE_DEPTH);

  logic signed [15:0] center [3];
  logic signed [15:0] smat [6];
  logic signed [15:0] charge;
  logic signed [15:0] jscale;

  logic               en;
  logic signed [COORD_WIDTH-1:0] pos [3];

  logic               f_valid;
  prod_t              f_y [3];
  logic signed [63:0] f_m [6];
  logic [IW-1:0]      f_idx;
  logic               f_rng;

  logic               x_valid;
  logic signed [31:0] x_e;
  prod_t              x_y [3];
  logic signed [63:0] x_m [6];

  // Advance every stage unless a finished result is waiting on the consumer.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos[i] = s_axis_tdata[COORD_WIDTH*i +: COORD_WIDTH];
    end
  end

  // Configuration registers; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '{default: '0};
      smat   <= '{default: '0};
      charge <= '0;
      jscale <= 16'sd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER: begin
          for (int i = 0; i < 3; i++) center[i] <= cfg_data[16*i +: 16];
        end
        REG_DIAG: begin
          smat[0] <= cfg_data[15:0];
          smat[3] <= cfg_data[31:16];
          smat[5] <= cfg_data[47:32];
        end
        REG_OFFDIAG: begin
          smat[1] <= cfg_data[15:0];
          smat[2] <= cfg_data[31:16];
          smat[4] <= cfg_data[47:32];
        end
        REG_CHARGE: charge <= cfg_data[15:0];
        REG_JSCALE: jscale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gpfk_front #(
    .COORD_WIDTH     (COORD_WIDTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid && s_axis_tready),
    .pos       (pos),
    .center    (center),
    .smat      (smat),
    .out_valid (f_valid),
    .y_out     (f_y),
    .m_out     (f_m),
    .idx_out   (f_idx),
    .in_range  (f_rng)
  );

  gpfk_exp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .idx       (f_idx),
    .in_range  (f_rng),
    .y_in      (f_y),
    .m_in      (f_m),
    .charge    (charge),
    .out_valid (x_valid),
    .energy    (x_e),
    .y_out     (x_y),
    .m_out     (x_m)
  );

  gpfk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x_valid),
    .energy    (x_e),
    .y_in      (x_y),
    .m_in      (x_m),
    .jscale    (jscale),
    .out_valid (m_axis_tvalid),
    .result    (m_axis_tdata)
  );

endmodule

[sv/gpfk_checker.sv]
// Port-level checks for the Gaussian force kernel, bound to the top level.
module gpfk_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [319:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_zero_energy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[127:96] == 32'd0 |->
      m_axis_tdata[95:0] == 96'd0 && m_axis_tdata[319:128] == 192'd0)
    else $error("nonzero force or Jacobian with zero energy");

endmodule

bind gaussian_potential_force_kernel_core gpfk_checker u_gpfk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/tb.sv]
// Self-checking testbench for the Gaussian potential force and Jacobian kernel.
module tb;
  import gpfk_pkg::*;

  localparam int DEPTH     = 1024;
  localparam int LIMIT     = 600000;
  localparam int MAX_SHOWN = 10;
  // Index past the register list; such a write must be dropped.
  localparam logic [2:0] BAD_INDEX_A = 3'd5;
  localparam logic [2:0] BAD_INDEX_B = 3'd7;
  localparam longint Q_TABLE_END = 64'sd1 <<< 29;
  localparam longint PRODUCT_CAP = 64'sd1 <<< 60;

  typedef struct {
    logic [47:0]  pos;
    bit           typed;   // expectation written out by hand
    logic [319:0] want;
    int           group;   // 0: reset registers, 1: unit Gaussian
  } vertex_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // pos_x, pos_y, pos_z from bit 0 up
  logic [47:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // force_x, force_y, force_z, vertex_energy, jac_xx, jac_xy, jac_xz,
  // jac_yy, jac_yz, jac_zz from bit 0 up
  logic [319:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;

  // Shadow copy of the kernel configuration.
  longint       center_v [3];
  longint       inv_cov [3][3];
  longint       charge_v;
  longint       jscale_v;
  longint       exp_rom [DEPTH];

  logic [319:0] pending_results [$];
  vertex_row_t  dir_rows [$];
  int           idle_pct = 36;
  int           mismatches = 0;
  int           cycles = 0;

  gaussian_potential_force_kernel_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Build exp(-16k/DEPTH) in Q2.30: Taylor series of exp(-x/32), squared five times.
  function automatic void build_exp_rom();
    longint t, term, acc;
    for (int k = 0; k < DEPTH; k++) begin
      t = (longint'(k) <<< 29) / DEPTH;
      term = 64'sd1 <<< 30;
      acc = term;
      for (int i = 1; i <= 12; i++) begin
        term = ((term * t) >>> 30) / i;
        acc = (i % 2 == 1) ? acc - term : acc + term;
      end
      for (int n = 0; n < 5; n++) acc = (acc * acc + (64'sd1 <<< 29)) >>> 30;
      exp_rom[k] = acc;
    end
  endfunction

  // Product clamped to +-2^60.
  function automatic longint clamp_mul(longint a, longint b);
    logic signed [127:0] p;
    p = a * b;
    if (p > PRODUCT_CAP) return PRODUCT_CAP;
    if (p < -PRODUCT_CAP) return -PRODUCT_CAP;
    return longint'(p);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Force, energy and Jacobian for one vertex under the shadow configuration.
  function automatic logic [319:0] vertex_response(logic [47:0] pos);
    logic [319:0] r;
    longint d [3];
    longint y [3];
    longint q, e, idx, m, t;
    int     ra [6] = '{0, 0, 0, 1, 1, 2};
    int     cb [6] = '{0, 1, 2, 1, 2, 2};
    q = 0;
    e = 0;
    for (int i = 0; i < 3; i++) d[i] = longint'($signed(pos[16*i +: 16])) - center_v[i];
    for (int i = 0; i < 3; i++) begin
      y[i] = 0;
      for (int j = 0; j < 3; j++) y[i] += inv_cov[i][j] * d[j];
    end
    for (int i = 0; i < 3; i++) q += clamp_mul(d[i], y[i]);
    if (q < 0) q = 0;
    if (q < Q_TABLE_END) begin
      idx = (q * DEPTH) >>> 29;
      if (idx >= DEPTH) idx = DEPTH - 1;
      e = (charge_v * exp_rom[idx]) >>> 22;
    end
    for (int i = 0; i < 3; i++) r[32*i +: 32] = clip32(clamp_mul(y[i], e) >>> 16);
    r[96 +: 32] = clip32(e);
    for (int i = 0; i < 6; i++) begin
      m = inv_cov[ra[i]][cb[i]] * (64'sd1 <<< 24) - clamp_mul(y[ra[i]], y[cb[i]]);
      t = clamp_mul(m >>> 16, e) >>> 16;
      r[128 + 32*i +: 32] = clip32(clamp_mul(t, jscale_v) >>> 8);
    end
    return r;
  endfunction

  function automatic void shadow_write(logic [2:0] index, logic [47:0] data);
    case (index)
      REG_CENTER: for (int i = 0; i < 3; i++) center_v[i] = longint'($signed(data[16*i +: 16]));
      REG_DIAG:   for (int i = 0; i < 3; i++) inv_cov[i][i] = longint'($signed(data[16*i +: 16]));
      REG_OFFDIAG: begin
        inv_cov[0][1] = longint'($signed(data[15:0]));
        inv_cov[1][0] = inv_cov[0][1];
        inv_cov[0][2] = longint'($signed(data[31:16]));
        inv_cov[2][0] = inv_cov[0][2];
        inv_cov[1][2] = longint'($signed(data[47:32]));
        inv_cov[2][1] = inv_cov[1][2];
      end
      REG_CHARGE: charge_v = longint'($signed(data[15:0]));
      REG_JSCALE: jscale_v = longint'($signed(data[15:0]));
      default: ;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] index, logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_write(index, data);
  endtask

  // Let every expected result drain, then cover the pipeline depth.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  // Drive one vertex; valid stays high across back-to-back transfers.
  task automatic send_vertex(logic [47:0] pos, bit typed, logic [319:0] want);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pos;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(typed ? want : vertex_response(pos));
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Take results with random stalls and check every field.
  always @(posedge clk) begin
    logic [319:0] want;
    m_axis_tready <= !rst && ($urandom_range(99) >= idle_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        for (int f = 0; f < 10; f++) begin
          if (m_axis_tdata[32*f +: 32] !== want[32*f +: 32]) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("field %0d: expected %h, got %h", f, want[32*f +: 32],
                       m_axis_tdata[32*f +: 32]);
          end
        end
      end
    end
  end

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [47:0] pack_xyz(logic [15:0] x, logic [15:0] yv, logic [15:0] z);
    return {z, yv, x};
  endfunction

  function automatic void add_row(logic [47:0] pos, bit typed, logic [319:0] want, int group);
    vertex_row_t r;
    r.pos = pos;
    r.typed = typed;
    r.want = want;
    r.group = group;
    dir_rows.push_back(r);
  endfunction

  // Random configuration; mostly moderate so the table is actually reached.
  task automatic random_setup(bit extreme);
    logic [47:0] v;
    if (extreme) begin
      write_reg(REG_CENTER, pack_xyz(pick_extreme(), pick_extreme(), pick_extreme()));
      write_reg(REG_DIAG, pack_xyz(pick_extreme(), pick_extreme(), pick_extreme()));
      write_reg(REG_OFFDIAG, pack_xyz(pick_extreme(), pick_extreme(), pick_extreme()));
      write_reg(REG_CHARGE, {32'h0, $urandom_range(1) ? 16'h8000 : 16'h7FFF});
      write_reg(REG_JSCALE, {32'h0, pick_extreme()});
    end else begin
      write_reg(REG_CENTER, {16'($urandom), 16'($urandom), 16'($urandom)});
      v = pack_xyz(16'($urandom_range(8, 512)), 16'($urandom_range(8, 512)),
                   16'($urandom_range(8, 512)));
      if ($urandom_range(7) == 0) v[15:0] = -v[15:0];   // not positive definite
      write_reg(REG_DIAG, v);
      write_reg(REG_OFFDIAG, {16'($signed($urandom_range(0, 128)) - 64),
                              16'($signed($urandom_range(0, 128)) - 64),
                              16'($signed($urandom_range(0, 128)) - 64)});
      write_reg(REG_CHARGE, {32'h0, 16'($urandom)});
      write_reg(REG_JSCALE, {32'h0, 16'($urandom)});
    end
  endtask

  function automatic logic [47:0] near_center();
    logic [47:0] p;
    for (int i = 0; i < 3; i++)
      p[16*i +: 16] = 16'(center_v[i] + longint'($urandom_range(0, 2048)) - 1024);
    return p;
  endfunction

  initial begin
    logic [319:0] unit_e;
    logic [47:0]  p;
    build_exp_rom();
    for (int i = 0; i < 3; i++) begin
      center_v[i] = 0;
      for (int j = 0; j < 3; j++) inv_cov[i][j] = 0;
    end
    charge_v = 0;
    jscale_v = 256;

    // Zero charge after reset: every output is zero.
    add_row(pack_xyz(16'h8000, 16'h8000, 16'h8000), 1, '0, 0);
    add_row(pack_xyz(16'h7FFF, 16'h7FFF, 16'h7FFF), 1, '0, 0);
    add_row(pack_xyz(16'h0000, 16'hFFFF, 16'h8000), 1, '0, 0);
    add_row(pack_xyz(16'h7FFF, 16'h0000, 16'hFFFF), 1, '0, 0);
    // Unit Gaussian, charge 1.0: at the center energy and diagonal Jacobian are 1.0.
    unit_e = '0;
    unit_e[96 +: 32]  = 32'h0001_0000;
    unit_e[128 +: 32] = 32'h0001_0000;
    unit_e[224 +: 32] = 32'h0001_0000;
    unit_e[288 +: 32] = 32'h0001_0000;
    add_row(pack_xyz(16'h0000, 16'h0000, 16'h0000), 1, unit_e, 1);
    // Sixteen units out: past the table end, everything zero.
    add_row(pack_xyz(16'h1000, 16'h0000, 16'h0000), 1, '0, 1);
    add_row(pack_xyz(16'h0000, 16'hF000, 16'h0000), 1, '0, 1);
    add_row(pack_xyz(16'h0100, 16'h0000, 16'h0000), 0, '0, 1);
    add_row(pack_xyz(16'h0000, 16'h0180, 16'hFF00), 0, '0, 1);
    add_row(pack_xyz(16'h0001, 16'hFFFF, 16'h0040), 0, '0, 1);
    add_row(pack_xyz(16'h0596, 16'h0000, 16'h0000), 0, '0, 1);   // just inside the table
    add_row(pack_xyz(16'h8000, 16'h7FFF, 16'h8000), 0, '0, 1);
    add_row(pack_xyz(16'h7FFF, 16'h7FFF, 16'h7FFF), 0, '0, 1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      if (dir_rows[i].group == 0) send_vertex(dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].want);
    end_burst();
    wait_drained();
    write_reg(REG_DIAG, pack_xyz(16'h0100, 16'h0100, 16'h0100));
    write_reg(REG_CHARGE, 48'h100);
    foreach (dir_rows[i])
      if (dir_rows[i].group == 1) send_vertex(dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].want);
    end_burst();
    wait_drained();

    // Indefinite matrix drives the quadratic form negative; overflow with big terms.
    write_reg(REG_DIAG, pack_xyz(16'hFF00, 16'h0100, 16'h0100));
    write_reg(REG_OFFDIAG, pack_xyz(16'h7FFF, 16'h8000, 16'h7FFF));
    write_reg(REG_CHARGE, 48'h7FFF);
    write_reg(REG_JSCALE, 48'h8000);
    write_reg(BAD_INDEX_A, 48'hFFFF_FFFF_FFFF);   // dropped by the kernel
    write_reg(BAD_INDEX_B, 48'h1234_5678_9ABC);
    send_vertex(pack_xyz(16'h0300, 16'h0000, 16'h0000), 0, '0);
    send_vertex(pack_xyz(16'h0001, 16'hFFFF, 16'h0001), 0, '0);
    send_vertex(pack_xyz(16'h0040, 16'h0040, 16'hFFC0), 0, '0);
    send_vertex(pack_xyz(16'h0000, 16'h0000, 16'h0000), 0, '0);
    end_burst();
    wait_drained();

    // Random phases; one runs with no idling, two with extreme settings.
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph == 3) ? 0 : 36;
      random_setup(ph == 5 || ph == 7);
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(9) < 7) p = near_center();
        else p = {16'($urandom), 16'($urandom), 16'($urandom)};
        send_vertex(p, 0, '0);
      end
      end_burst();
      wait_drained();   // the sender holds off until every result is back
    end

    idle_pct = 36;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/gpfk_pkg.sv
sv/gpfk_front.sv
sv/gpfk_exp.sv
sv/gpfk_back.sv
sv/gaussian_potential_force_kernel_core.sv
sv/gpfk_checker.sv
tb/tb.sv
